>>> rtl/core/assert_macros.svh
// Assertion helpers shared by the RTL. Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/core/cbd_pkg.sv
package cbd_pkg;

	localparam logic [7:0] CH_LF   = 8'h0A;
	localparam logic [7:0] CH_CR   = 8'h0D;
	localparam logic [7:0] CH_TAB  = 8'h09;
	localparam logic [7:0] CH_VT   = 8'h0B;
	localparam logic [7:0] CH_FF   = 8'h0C;
	localparam logic [7:0] CH_SP   = 8'h20;
	localparam logic [7:0] CH_SEMI = 8'h3B;

	localparam logic [7:0] DIGIT_OFS = 8'h30;
	localparam logic [7:0] LOWER_OFS = 8'h57;
	localparam logic [7:0] UPPER_OFS = 8'h37;

	localparam logic [1:0] MAX_NON_LF = 2'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	typedef enum logic [1:0] {
		ERR_NONE = 2'd0,
		ERR_SIZE = 2'd1,
		ERR_CRLF = 2'd2
	} err_code_t;

	typedef enum logic [2:0] {
		PH_SIZE,
		PH_DATA,
		PH_CRLF,
		PH_TRAILER,
		PH_DONE
	} phase_t;

	typedef enum logic [1:0] {
		SUB_BEFORE,
		SUB_DIGITS,
		SUB_AFTER,
		SUB_EXT
	} size_sub_t;

	typedef enum logic [1:0] {
		TL_EMPTY,
		TL_CR,
		TL_TEXT
	} trailer_kind_t;

	// One classified input byte as it travels through the queue.
	typedef struct packed {
		logic [7:0] raw;
		logic       is_lf;
		logic       is_cr;
		logic       is_semi;
		logic       is_space;
		logic       is_hex;
		logic [3:0] hex_val;
	} byte_class_t;

	typedef struct packed {
		logic      done;
		err_code_t err;
	} dec_status_t;

endpackage

>>> rtl/core/cbd_if.sv
interface cbd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

interface cbd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] payload_byte;
	logic       payload_valid;
	logic       consumed;
	logic       done_res;
	logic [1:0] error_code;

	modport source (output valid, output payload_byte, output payload_valid,
		output consumed, output done_res, output error_code, input ready);
	modport sink (input valid, input payload_byte, input payload_valid,
		input consumed, input done_res, input error_code, output ready);
endinterface

>>> rtl/core/cbd_front.sv
module cbd_front (
	cbd_in_if.sink              din,
	input  logic                full,
	output logic                push,
	output cbd_pkg::byte_class_t push_data
);
	import cbd_pkg::*;

	logic [7:0] b;

	assign b         = din.in_byte;
	assign din.ready = !full;
	assign push      = din.valid && !full;

	always_comb begin
		push_data.raw      = b;
		push_data.is_lf    = (b == CH_LF);
		push_data.is_cr    = (b == CH_CR);
		push_data.is_semi  = (b == CH_SEMI);
		push_data.is_space = b inside {CH_SP, CH_TAB, CH_CR, CH_VT, CH_FF};
		push_data.is_hex   = 1'b1;
		push_data.hex_val  = 4'd0;
		case (b) inside
			[8'h30:8'h39]: begin
				push_data.hex_val = 4'(b - DIGIT_OFS);
			end
			[8'h61:8'h66]: begin
				push_data.hex_val = 4'(b - LOWER_OFS);
			end
			[8'h41:8'h46]: begin
				push_data.hex_val = 4'(b - UPPER_OFS);
			end
			default: begin
				push_data.is_hex = 1'b0;
			end
		endcase
	end

endmodule

>>> rtl/core/cbd_queue.sv
module cbd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  cbd_pkg::byte_class_t push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 head_valid,
	output cbd_pkg::byte_class_t head
);
	import cbd_pkg::*;

	byte_class_t        entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_push;
	logic               do_pop;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = entry_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/cbd_back.sv
module cbd_back #(
	parameter int SIZE_BITS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_valid,
	input  cbd_pkg::byte_class_t head,
	output logic                 pop,
	cbd_out_if.source            dout,
	output cbd_pkg::dec_status_t status
);
	import cbd_pkg::*;

	phase_t                phase_q, phase_d;
	size_sub_t             sub_q, sub_d;
	logic [SIZE_BITS-1:0]  accum_q, accum_d;
	logic [SIZE_BITS-1:0]  remain_q, remain_d;
	logic [1:0]            crlf_q, crlf_d;
	trailer_kind_t         tkind_q, tkind_d;
	err_code_t             err_q, err_d;

	logic                  out_valid_q;
	logic [7:0]            out_byte_q;
	logic                  out_pvalid_q;
	logic                  out_used_q;
	logic                  out_done_q;
	err_code_t             out_err_q;

	logic                  fire;
	logic [7:0]            pay;
	logic                  pvalid;
	logic                  used;

	assign fire = head_valid && (!out_valid_q || dout.ready);
	assign pop  = fire;

	always_comb begin
		phase_d  = phase_q;
		sub_d    = sub_q;
		accum_d  = accum_q;
		remain_d = remain_q;
		crlf_d   = crlf_q;
		tkind_d  = tkind_q;
		err_d    = err_q;
		pay      = 8'd0;
		pvalid   = 1'b0;
		used     = 1'b0;
		if (err_q == ERR_NONE && phase_q != PH_DONE) begin
			used = 1'b1;
			case (phase_q)
				PH_SIZE: begin
					if (head.is_lf) begin
						if (sub_q == SUB_BEFORE) begin
							err_d = ERR_SIZE;
						end else if (accum_q == '0) begin
							phase_d = PH_TRAILER;
							tkind_d = TL_EMPTY;
						end else begin
							remain_d = accum_q;
							phase_d  = PH_DATA;
						end
						sub_d   = SUB_BEFORE;
						accum_d = '0;
					end else if (sub_q == SUB_EXT) begin
						// Extension text is skipped up to the line end.
					end else if (head.is_semi) begin
						if (sub_q == SUB_BEFORE) begin
							err_d = ERR_SIZE;
						end else begin
							sub_d = SUB_EXT;
						end
					end else if (head.is_space) begin
						if (sub_q == SUB_DIGITS) begin
							sub_d = SUB_AFTER;
						end
					end else if (!head.is_hex || sub_q == SUB_AFTER) begin
						err_d = ERR_SIZE;
					end else if (accum_q[SIZE_BITS-1 -: 4] != 4'd0) begin
						// Another digit would shift a set bit out of the size.
						err_d = ERR_SIZE;
					end else begin
						accum_d = {accum_q[SIZE_BITS-5:0], head.hex_val};
						sub_d   = SUB_DIGITS;
					end
				end
				PH_DATA: begin
					pay      = head.raw;
					pvalid   = 1'b1;
					remain_d = remain_q - 1'b1;
					if (remain_q == SIZE_BITS'(1)) begin
						phase_d = PH_CRLF;
						crlf_d  = 2'd0;
					end
				end
				PH_CRLF: begin
					if (head.is_lf) begin
						phase_d = PH_SIZE;
						sub_d   = SUB_BEFORE;
						accum_d = '0;
						crlf_d  = 2'd0;
					end else if (crlf_q >= MAX_NON_LF) begin
						err_d = ERR_CRLF;
					end else begin
						crlf_d = crlf_q + 1'b1;
					end
				end
				PH_TRAILER: begin
					if (head.is_lf) begin
						if (tkind_q != TL_TEXT) begin
							phase_d = PH_DONE;
						end
						tkind_d = TL_EMPTY;
					end else if (head.is_cr && tkind_q == TL_EMPTY) begin
						tkind_d = TL_CR;
					end else begin
						tkind_d = TL_TEXT;
					end
				end
				default: begin
					used = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_SIZE;
			sub_q       <= SUB_BEFORE;
			accum_q     <= '0;
			remain_q    <= '0;
			crlf_q      <= 2'd0;
			tkind_q     <= TL_EMPTY;
			err_q       <= ERR_NONE;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				phase_q     <= phase_d;
				sub_q       <= sub_d;
				accum_q     <= accum_d;
				remain_q    <= remain_d;
				crlf_q      <= crlf_d;
				tkind_q     <= tkind_d;
				err_q       <= err_d;
				out_valid_q <= 1'b1;
			end else if (dout.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_byte_q   <= pay;
			out_pvalid_q <= pvalid;
			out_used_q   <= used;
			out_done_q   <= (phase_d == PH_DONE);
			out_err_q    <= err_d;
		end
	end

	assign dout.valid         = out_valid_q;
	assign dout.payload_byte  = out_byte_q;
	assign dout.payload_valid = out_pvalid_q;
	assign dout.consumed      = out_used_q;
	assign dout.done_res      = out_done_q;
	assign dout.error_code    = out_err_q;

	assign status.done = (phase_q == PH_DONE);
	assign status.err  = err_q;

endmodule

>>> rtl/core/chunked_body_decoder_top.sv
// A byte accepted from din is first written into a queue entry, then decoded into the
// result register that drives dout; earlier queued bytes or a stalled dout delay it.
// Throughput: one byte per cycle while dout is not stalled; a 4-entry queue sits
// between the classifier and the decoder.
// Reset: arst_n clears the queue, the decoder state and the output valid flag at once.
`include "assert_macros.svh"

module chunked_body_decoder_top #(
	parameter int SIZE_BITS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	cbd_in_if.sink     din,
	cbd_out_if.source  dout
);
	import cbd_pkg::*;

	logic        q_full;
	logic        q_push;
	byte_class_t q_push_data;
	logic        q_pop;
	logic        q_head_valid;
	byte_class_t q_head;
	dec_status_t status;
	logic        out_data;
	logic        out_clean;

	cbd_front u_front (
		.din       (din),
		.full      (q_full),
		.push      (q_push),
		.push_data (q_push_data)
	);

	cbd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_data  (q_push_data),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_head_valid),
		.head       (q_head)
	);

	cbd_back #(
		.SIZE_BITS (SIZE_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (q_head_valid),
		.head       (q_head),
		.pop        (q_pop),
		.dout       (dout),
		.status     (status)
	);

	assign out_data  = dout.valid && dout.payload_valid;
	assign out_clean = dout.consumed && !dout.done_res && dout.error_code == ERR_NONE;

	// A latched error never changes again.
	`ASSERT_NEXT(a_err_sticky, clk, arst_n, status.err != ERR_NONE, $stable(status.err))
	// Completion and an error exclude each other.
	`ASSERT_IMPLIES(a_done_no_err, clk, arst_n, status.done, status.err == ERR_NONE)
	// A data byte is only delivered by a decoder that is still working.
	`ASSERT_IMPLIES(a_payload_clean, clk, arst_n, out_data, out_clean)

endmodule
